>>> rtl/lfs_pkg.sv
package lfs_pkg;

	localparam int LetterCount = 26;
	localparam int IdxBits = 5;
	localparam logic [6:0] LetterBase = 7'h41;
	localparam logic [7:0] CaseMask = 8'hdf;
	localparam logic [7:0] UpperA = 8'h41;
	localparam logic [7:0] UpperZ = 8'h5a;
	localparam logic [6:0] Hundred = 7'd100;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [31:0] count_in;
		logic        last_entry;
	} req_t;

	typedef struct packed {
		logic        list_kind;
		logic [6:0]  letter_code;
		logic [32:0] letter_count;
		logic [6:0]  percent;
		logic        status;
		logic        last_result;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_SORT,
		ST_EMIT,
		ST_DIV,
		ST_OUT,
		ST_EMPTY,
		ST_CLEAR
	} back_state_t;

	typedef struct packed {
		logic       valid;
		logic       is_letter;
		logic [4:0] idx;
		logic       last;
	} cls_t;

endpackage

>>> rtl/lfs_front.sv
module lfs_front #(
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  lfs_pkg::req_t         req,
	output lfs_pkg::cls_t         cls_s1,
	output logic [COUNT_BITS-1:0] cnt_s1
);
	logic [7:0] up;
	assign up = req.byte_value & lfs_pkg::CaseMask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_s1 <= '0;
		end else begin
			cls_s1.valid <= take;
			cls_s1.is_letter <= (up >= lfs_pkg::UpperA) && (up <= lfs_pkg::UpperZ);
			cls_s1.idx <= 5'(up - lfs_pkg::UpperA);
			cls_s1.last <= req.last_entry;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1 <= COUNT_BITS'(req.count_in);
	end
endmodule

>>> rtl/lfs_back.sv
module lfs_back #(
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lfs_pkg::cls_t         cls_s1,
	input  logic [COUNT_BITS-1:0] cnt_s1,
	output logic                  busy_back,
	output logic                  result_valid,
	output lfs_pkg::res_t         result
);
	localparam int CW = COUNT_BITS + 1;
	localparam int TW = COUNT_BITS + 6;
	localparam int NW = CW + 7;
	localparam logic [CW-1:0] CntMax = '1;

	logic [CW-1:0] cnt_q [lfs_pkg::LetterCount];
	logic [4:0]    ord_q [lfs_pkg::LetterCount];
	logic [TW-1:0] total_q;
	lfs_pkg::back_state_t st_q, st_d;
	logic [4:0] i_q, j_q;
	logic       kind_q;
	logic [4:0] cur_q;
	logic [NW-1:0] rem_q;
	logic [6:0] quo_q;
	logic [2:0] bit_q;
	logic [CW-1:0] sum_ext;
	logic [CW:0]   sum_add;
	logic [4:0]    ins_v;
	logic          shift_ok;
	logic [NW+6:0] dividend;

	assign sum_add = {1'b0, cnt_q[cls_s1.idx]} + {1'b0, CntMax & CW'(cnt_s1)};
	assign sum_ext = sum_add[CW] ? CntMax : sum_add[CW-1:0];
	assign ins_v = i_q;
	assign shift_ok = (j_q != 5'd0) && (cnt_q[ord_q[j_q - 5'd1]] < cnt_q[ins_v]);
	assign dividend = {7'd0, cnt_q[cur_q]} * (NW+7)'(lfs_pkg::Hundred);

	always_comb begin
		st_d = st_q;
		case (st_q)
			lfs_pkg::ST_IDLE:  if (cls_s1.valid && cls_s1.last) st_d = lfs_pkg::ST_TOTAL;
			lfs_pkg::ST_TOTAL: if (i_q == 5'(lfs_pkg::LetterCount - 1)) st_d = lfs_pkg::ST_SORT;
			lfs_pkg::ST_SORT: begin
				if (total_q == '0) st_d = lfs_pkg::ST_EMPTY;
				else if (!shift_ok && i_q == 5'(lfs_pkg::LetterCount - 1)) st_d = lfs_pkg::ST_EMIT;
			end
			lfs_pkg::ST_EMIT:  st_d = lfs_pkg::ST_DIV;
			lfs_pkg::ST_DIV:   if (bit_q == 3'd0 && i_q == 5'd0) st_d = lfs_pkg::ST_OUT;
			lfs_pkg::ST_OUT: begin
				if (kind_q && j_q == 5'(lfs_pkg::LetterCount - 1)) st_d = lfs_pkg::ST_CLEAR;
				else st_d = lfs_pkg::ST_EMIT;
			end
			lfs_pkg::ST_EMPTY: st_d = lfs_pkg::ST_CLEAR;
			lfs_pkg::ST_CLEAR: st_d = lfs_pkg::ST_IDLE;
			default:           st_d = lfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy_back = (st_q != lfs_pkg::ST_IDLE) || (cls_s1.valid && cls_s1.last);
		result_valid = (st_q == lfs_pkg::ST_OUT) || (st_q == lfs_pkg::ST_EMPTY);
		result = '0;
		if (st_q == lfs_pkg::ST_EMPTY) begin
			result.status = 1'b1;
			result.last_result = 1'b1;
		end else begin
			result.list_kind = kind_q;
			result.letter_code = lfs_pkg::LetterBase + 7'(cur_q);
			result.letter_count = 33'(cnt_q[cur_q]);
			result.percent = quo_q;
			result.last_result = kind_q && (j_q == 5'(lfs_pkg::LetterCount - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lfs_pkg::ST_IDLE;
			total_q <= '0;
			i_q <= '0;
			j_q <= '0;
			kind_q <= 1'b0;
			for (int k = 0; k < lfs_pkg::LetterCount; k++) cnt_q[k] <= '0;
		end else begin
			st_q <= st_d;
			if (cls_s1.valid && cls_s1.is_letter && st_q == lfs_pkg::ST_IDLE)
				cnt_q[cls_s1.idx] <= sum_ext;
			case (st_q)
				lfs_pkg::ST_IDLE: begin
					i_q <= '0;
					total_q <= '0;
				end
				lfs_pkg::ST_TOTAL: begin
					total_q <= total_q + TW'(cnt_q[i_q]);
					if (i_q == 5'(lfs_pkg::LetterCount - 1)) begin
						i_q <= '0;
						j_q <= '0;
					end else i_q <= i_q + 5'd1;
				end
				lfs_pkg::ST_SORT: begin
					if (shift_ok) begin
						ord_q[j_q] <= ord_q[j_q - 5'd1];
						j_q <= j_q - 5'd1;
					end else begin
						ord_q[j_q] <= ins_v;
						if (i_q == 5'(lfs_pkg::LetterCount - 1)) begin
							j_q <= '0;
							kind_q <= 1'b0;
							i_q <= '0;
						end else begin
							i_q <= i_q + 5'd1;
							j_q <= i_q + 5'd1;
						end
					end
				end
				lfs_pkg::ST_EMIT: begin
					i_q <= 5'd1;
				end
				lfs_pkg::ST_DIV: begin
					if (i_q != 5'd0) i_q <= 5'd0;
				end
				lfs_pkg::ST_OUT: begin
					if (j_q == 5'(lfs_pkg::LetterCount - 1)) begin
						j_q <= '0;
						kind_q <= 1'b1;
					end else j_q <= j_q + 5'd1;
				end
				lfs_pkg::ST_CLEAR: begin
					for (int k = 0; k < lfs_pkg::LetterCount; k++) cnt_q[k] <= '0;
					kind_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// radix-2 restoring division of count*100 by total, one quotient bit a cycle, then round half to even
	logic [NW+6:0] num_q;
	logic [6:0]    step_q;

	always_ff @(posedge clk) begin
		if (st_q == lfs_pkg::ST_EMIT) begin
			cur_q <= kind_q ? ord_q[j_q] : j_q;
			step_q <= 7'd0;
			bit_q <= 3'd1;
			quo_q <= '0;
			rem_q <= '0;
		end else if (st_q == lfs_pkg::ST_DIV) begin
			if (step_q == 7'd0) begin
				num_q <= dividend;
				rem_q <= '0;
				step_q <= 7'd1;
				bit_q <= 3'd1;
			end else if (step_q <= 7'(NW)) begin
				logic [TW:0] r2;
				r2 = {rem_q[NW-1 -: TW], num_q[NW-1]};
				num_q <= num_q << 1;
				if (r2 >= {1'b0, total_q}) begin
					rem_q[NW-1 -: TW] <= TW'(r2 - {1'b0, total_q});
					quo_q <= {quo_q[5:0], 1'b1};
				end else begin
					rem_q[NW-1 -: TW] <= r2[TW-1:0];
					quo_q <= {quo_q[5:0], 1'b0};
				end
				step_q <= step_q + 7'd1;
				if (step_q == 7'(NW)) bit_q <= 3'd0;
			end else if (bit_q == 3'd0) begin
				if (({rem_q[NW-1 -: TW], 1'b0} > {1'b0, total_q}) ||
					(({rem_q[NW-1 -: TW], 1'b0} == {1'b0, total_q}) && quo_q[0]))
					quo_q <= quo_q + 7'd1;
			end
		end
	end
endmodule

>>> rtl/letter_frequency_sorter_unit.sv
// Letter frequency sorter. Histogram entries are requested with start while busy is low;
// busy is also raised while an accepted entry sits in the front register. After the entry
// marked last the block sums the 26 counters, insertion-sorts them and then emits 52
// results, each after a bit-serial rounding division, or a single no-letters result.
// Results appear for one cycle with result_valid and cannot be stalled; busy stays high
// until the run is done.
module letter_frequency_sorter_unit #(
	parameter int COUNT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lfs_pkg::req_t req,
	output logic          result_valid,
	output lfs_pkg::res_t result
);
	lfs_pkg::cls_t         cls_s1;
	logic [COUNT_BITS-1:0] cnt_s1;
	logic                  busy_back;

	assign busy = busy_back || cls_s1.valid;

	lfs_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(start && !busy), .req(req),
		.cls_s1(cls_s1), .cnt_s1(cnt_s1)
	);

	lfs_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cls_s1(cls_s1), .cnt_s1(cnt_s1),
		.busy_back(busy_back), .result_valid(result_valid), .result(result)
	);
endmodule

>>> rtl/lfs_checker.sv
module lfs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          result_valid,
	input lfs_pkg::res_t result
);
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after request");
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.status |-> result.letter_code >= 7'h41 &&
		result.letter_code <= 7'h5a) else $error("letter code out of range");
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.percent <= 7'd100) else $error("percent out of range");
	a_busy_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result while idle");
endmodule

bind letter_frequency_sorter_unit lfs_checker u_lfs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .result(result)
);
